>>> hw/rtl/tlb_page_table_translator_assert.svh
// Assertion macros shared by the translator top level.
`ifndef TLB_PAGE_TABLE_TRANSLATOR_ASSERT_SVH
`define TLB_PAGE_TABLE_TRANSLATOR_ASSERT_SVH

// Check a same-cycle implication, sampled on clk, held off during reset.
`define TLBPT_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check an implication in the next cycle, sampled on clk, held off during reset.
`define TLBPT_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> hw/rtl/tlbpt_pkg.sv
`default_nettype none

package tlbpt_pkg;

	localparam int unsigned CFG_W = 9;
	localparam logic [CFG_W-1:0] CFG_RESET = 9'd256;
	localparam int unsigned CNT_W = 32;
	localparam logic [CNT_W-1:0] CNT_MAX = 32'hFFFF_FFFF;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_LOOKUP,
		ST_EVCHK,
		ST_EVFILL
	} state_t;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_CLEAR,
		OP_ACCEPT,
		OP_HIT,
		OP_MAP,
		OP_FREE,
		OP_EVSEL,
		OP_EVCHK,
		OP_EVFILL
	} op_t;

	typedef struct packed {
		op_t  op;
		logic load_out;
	} cmd_t;

	typedef struct packed {
		logic clear_last;
		logic tlb_found;
		logic map_valid;
		logic frames_free;
	} stat_t;

	function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
		return (v == CNT_MAX) ? v : v + 32'd1;
	endfunction

endpackage

`default_nettype wire

>>> hw/rtl/tlbpt_ctrl.sv
`default_nettype none

module tlbpt_ctrl (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	output logic                 in_stall,
	output logic                 out_valid,
	input  wire logic            out_stall,
	input  wire tlbpt_pkg::stat_t stat,
	output tlbpt_pkg::cmd_t      cmd
);

	tlbpt_pkg::state_t state_q, state_nxt;
	logic out_valid_q;
	logic slot_free;

	// Result register is free when empty or being drained this cycle.
	assign slot_free = !out_valid_q || !out_stall;
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tlbpt_pkg::ST_CLEAR;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// Next state.
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			tlbpt_pkg::ST_CLEAR: begin
				if (stat.clear_last) state_nxt = tlbpt_pkg::ST_IDLE;
			end
			tlbpt_pkg::ST_IDLE: begin
				if (in_valid) state_nxt = tlbpt_pkg::ST_LOOKUP;
			end
			tlbpt_pkg::ST_LOOKUP: begin
				if (stat.tlb_found || stat.map_valid || stat.frames_free) begin
					if (slot_free) state_nxt = tlbpt_pkg::ST_IDLE;
				end else begin
					state_nxt = tlbpt_pkg::ST_EVCHK;
				end
			end
			tlbpt_pkg::ST_EVCHK: begin
				state_nxt = tlbpt_pkg::ST_EVFILL;
			end
			tlbpt_pkg::ST_EVFILL: begin
				if (slot_free) state_nxt = tlbpt_pkg::ST_IDLE;
			end
			default: state_nxt = tlbpt_pkg::ST_CLEAR;
		endcase
	end

	// Commands.
	always_comb begin
		cmd.op       = tlbpt_pkg::OP_NONE;
		cmd.load_out = 1'b0;
		in_stall     = 1'b1;
		case (state_q)
			tlbpt_pkg::ST_CLEAR: begin
				cmd.op = tlbpt_pkg::OP_CLEAR;
			end
			tlbpt_pkg::ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) cmd.op = tlbpt_pkg::OP_ACCEPT;
			end
			tlbpt_pkg::ST_LOOKUP: begin
				if (stat.tlb_found) begin
					if (slot_free) begin
						cmd.op       = tlbpt_pkg::OP_HIT;
						cmd.load_out = 1'b1;
					end
				end else if (stat.map_valid) begin
					if (slot_free) begin
						cmd.op       = tlbpt_pkg::OP_MAP;
						cmd.load_out = 1'b1;
					end
				end else if (stat.frames_free) begin
					if (slot_free) begin
						cmd.op       = tlbpt_pkg::OP_FREE;
						cmd.load_out = 1'b1;
					end
				end else begin
					cmd.op = tlbpt_pkg::OP_EVSEL;
				end
			end
			tlbpt_pkg::ST_EVCHK: begin
				cmd.op = tlbpt_pkg::OP_EVCHK;
			end
			tlbpt_pkg::ST_EVFILL: begin
				if (slot_free) begin
					cmd.op       = tlbpt_pkg::OP_EVFILL;
					cmd.load_out = 1'b1;
				end
			end
			default: begin
				cmd.op = tlbpt_pkg::OP_NONE;
			end
		endcase
	end

endmodule

`default_nettype wire

>>> hw/rtl/tlbpt_dp.sv
`default_nettype none

module tlbpt_dp #(
	parameter int unsigned TLB_ENTRIES = 16,
	parameter int unsigned PAGE_COUNT  = 256,
	parameter int unsigned FRAME_COUNT = 256,
	parameter int unsigned OFFSET_BITS = 8
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_we,
	input  wire logic [tlbpt_pkg::CFG_W-1:0]     cfg_data,
	input  wire logic [15:0]                     virt_addr,
	input  wire tlbpt_pkg::cmd_t                 cmd,
	output tlbpt_pkg::stat_t                     stat,
	output logic [15:0]                          phys_addr,
	output logic                                 tlb_hit,
	output logic                                 page_fault,
	output logic [7:0]                           fetch_page,
	output logic [7:0]                           fetch_frame,
	output logic                                 evicted_valid,
	output logic [7:0]                           evicted_page,
	output logic [tlbpt_pkg::CNT_W-1:0]          hit_total,
	output logic [tlbpt_pkg::CNT_W-1:0]          fault_total,
	output logic [tlbpt_pkg::CNT_W-1:0]          access_total
);

	localparam int unsigned PAGE_W  = $clog2(PAGE_COUNT);
	localparam int unsigned FRAME_W = $clog2(FRAME_COUNT);
	localparam int unsigned TLB_W   = $clog2(TLB_ENTRIES);
	localparam int unsigned FCNT_W  = FRAME_W + 1;
	localparam int unsigned LIM_W   = (FCNT_W > tlbpt_pkg::CFG_W) ? FCNT_W : tlbpt_pkg::CFG_W;
	localparam logic [15:0] OFF_MASK = 16'((32'd1 << OFFSET_BITS) - 32'd1);

	logic [tlbpt_pkg::CFG_W-1:0] cfg_q;
	logic [PAGE_W-1:0]  page_q;
	logic [15:0]        offset_q;
	logic [FRAME_W:0]   pm_rd_q;
	logic [PAGE_W-1:0]  own_rd_q;
	logic [FRAME_W-1:0] frame_q;
	logic [PAGE_W-1:0]  ev_page_q;
	logic               ev_valid_q;
	logic [FCNT_W-1:0]  free_q;
	logic [FRAME_W-1:0] evict_q;
	logic [TLB_W-1:0]   fill_q;
	logic [PAGE_W-1:0]  clr_q;

	logic [FRAME_W:0]   pm_mem [PAGE_COUNT];
	logic [PAGE_W-1:0]  own_mem [FRAME_COUNT];

	logic [TLB_ENTRIES-1:0] tlb_vld_q;
	logic [PAGE_W-1:0]      tlb_page_q [TLB_ENTRIES];
	logic [FRAME_W-1:0]     tlb_frm_q [TLB_ENTRIES];

	logic [PAGE_W-1:0]  in_page;
	logic [LIM_W-1:0]   cfg_ext, lim_w;
	logic [FCNT_W-1:0]  lim;
	logic [FRAME_W-1:0] ev_frame, ev_next;
	logic               tlb_found;
	logic [FRAME_W-1:0] tlb_frame;
	logic [FRAME_W-1:0] commit_frame;
	logic               ev_match;
	logic               pm_we, pm_re;
	logic [PAGE_W-1:0]  pm_wa, pm_ra;
	logic [FRAME_W:0]   pm_wd;
	logic               own_we;
	logic               tlb_fill, tlb_drop, is_fault;

	// Page count is a power of two: the page is the bits above the offset.
	assign in_page = PAGE_W'(virt_addr >> OFFSET_BITS);

	// Clamp the frame limit to 1..FRAME_COUNT.
	assign cfg_ext = LIM_W'(cfg_q);
	assign lim_w   = (cfg_ext == '0) ? LIM_W'(1) :
		(cfg_ext > LIM_W'(FRAME_COUNT)) ? LIM_W'(FRAME_COUNT) : cfg_ext;
	assign lim     = FCNT_W'(lim_w);

	assign ev_frame = (FCNT_W'(evict_q) < lim) ? evict_q : '0;
	assign ev_next  = ((FCNT_W'(ev_frame) + FCNT_W'(1)) >= lim) ? '0 : ev_frame + FRAME_W'(1);

	always_comb begin
		tlb_found = 1'b0;
		tlb_frame = '0;
		for (int i = 0; i < TLB_ENTRIES; i++) begin
			if (!tlb_found && tlb_vld_q[i] && tlb_page_q[i] == page_q) begin
				tlb_found = 1'b1;
				tlb_frame = tlb_frm_q[i];
			end
		end
	end

	assign ev_match = pm_rd_q[FRAME_W] && (pm_rd_q[FRAME_W-1:0] == frame_q);

	always_comb begin
		case (cmd.op)
			tlbpt_pkg::OP_HIT:  commit_frame = tlb_frame;
			tlbpt_pkg::OP_MAP:  commit_frame = pm_rd_q[FRAME_W-1:0];
			tlbpt_pkg::OP_FREE: commit_frame = free_q[FRAME_W-1:0];
			default:            commit_frame = frame_q;
		endcase
	end

	assign stat.clear_last  = (clr_q == PAGE_W'(PAGE_COUNT - 1));
	assign stat.tlb_found   = tlb_found;
	assign stat.map_valid   = pm_rd_q[FRAME_W];
	assign stat.frames_free = (free_q < lim);

	assign is_fault = (cmd.op == tlbpt_pkg::OP_FREE) || (cmd.op == tlbpt_pkg::OP_EVFILL);
	assign own_we   = is_fault;
	assign tlb_fill = is_fault || (cmd.op == tlbpt_pkg::OP_MAP);
	assign tlb_drop = (cmd.op == tlbpt_pkg::OP_EVCHK) && ev_match;
	assign pm_re    = (cmd.op == tlbpt_pkg::OP_ACCEPT) || (cmd.op == tlbpt_pkg::OP_EVSEL);
	assign pm_ra    = (cmd.op == tlbpt_pkg::OP_ACCEPT) ? in_page : own_rd_q;

	always_comb begin
		pm_we = 1'b0;
		pm_wa = page_q;
		pm_wd = {1'b1, commit_frame};
		case (cmd.op)
			tlbpt_pkg::OP_CLEAR: begin
				pm_we = 1'b1;
				pm_wa = clr_q;
				pm_wd = '0;
			end
			tlbpt_pkg::OP_FREE, tlbpt_pkg::OP_EVFILL: begin
				pm_we = 1'b1;
			end
			tlbpt_pkg::OP_EVCHK: begin
				pm_we = ev_match;
				pm_wa = ev_page_q;
				pm_wd = '0;
			end
			default: pm_we = 1'b0;
		endcase
	end

	// Page table memory.
	always_ff @(posedge clk) begin
		if (pm_we) pm_mem[pm_wa] <= pm_wd;
		if (pm_re) pm_rd_q <= pm_mem[pm_ra];
	end

	// Frame owner memory.
	always_ff @(posedge clk) begin
		if (own_we) own_mem[commit_frame] <= page_q;
		if (cmd.op == tlbpt_pkg::OP_ACCEPT) own_rd_q <= own_mem[ev_frame];
	end

	always_ff @(posedge clk) begin
		if (cmd.op == tlbpt_pkg::OP_ACCEPT) begin
			page_q   <= in_page;
			offset_q <= virt_addr & OFF_MASK;
		end
		if (cmd.op == tlbpt_pkg::OP_EVSEL) begin
			frame_q   <= ev_frame;
			ev_page_q <= own_rd_q;
		end
		if (cmd.op == tlbpt_pkg::OP_EVCHK) ev_valid_q <= ev_match;
	end

	always_ff @(posedge clk) begin
		if (tlb_fill) begin
			tlb_page_q[fill_q] <= page_q;
			tlb_frm_q[fill_q]  <= commit_frame;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tlb_vld_q <= '0;
			fill_q    <= '0;
		end else begin
			if (tlb_fill) begin
				tlb_vld_q[fill_q] <= 1'b1;
				fill_q <= (fill_q == TLB_W'(TLB_ENTRIES - 1)) ? '0 : fill_q + TLB_W'(1);
			end
			if (tlb_drop) begin
				for (int i = 0; i < TLB_ENTRIES; i++) begin
					if (tlb_page_q[i] == ev_page_q) tlb_vld_q[i] <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q        <= tlbpt_pkg::CFG_RESET;
			free_q       <= '0;
			evict_q      <= '0;
			clr_q        <= '0;
			hit_total    <= '0;
			fault_total  <= '0;
			access_total <= '0;
		end else begin
			if (cfg_we) cfg_q <= cfg_data;
			if (cmd.op == tlbpt_pkg::OP_CLEAR) clr_q <= clr_q + PAGE_W'(1);
			if (cmd.op == tlbpt_pkg::OP_FREE) free_q <= free_q + FCNT_W'(1);
			if (cmd.op == tlbpt_pkg::OP_EVSEL) evict_q <= ev_next;
			if (cmd.op == tlbpt_pkg::OP_HIT) hit_total <= tlbpt_pkg::sat_inc(hit_total);
			if (is_fault) fault_total <= tlbpt_pkg::sat_inc(fault_total);
			if (cmd.load_out) access_total <= tlbpt_pkg::sat_inc(access_total);
		end
	end

	// Result word.
	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			phys_addr     <= 16'((32'(commit_frame) << OFFSET_BITS) | 32'(offset_q));
			tlb_hit       <= (cmd.op == tlbpt_pkg::OP_HIT);
			page_fault    <= is_fault;
			fetch_page    <= is_fault ? 8'(page_q) : 8'd0;
			fetch_frame   <= is_fault ? 8'(commit_frame) : 8'd0;
			evicted_valid <= (cmd.op == tlbpt_pkg::OP_EVFILL) && ev_valid_q;
			evicted_page  <= ((cmd.op == tlbpt_pkg::OP_EVFILL) && ev_valid_q) ?
				8'(ev_page_q) : 8'd0;
		end
	end

endmodule

`default_nettype wire

>>> hw/rtl/tlb_page_table_translator.sv
// Result: a word is registered at the end of the lookup state, or of the eviction fill state
// when a frame is evicted; a stalled result channel holds it back. Sequence: idle takes an
// address and starts the synchronous page-table read, lookup resolves it (TLB hit, table hit,
// free frame), an eviction adds the check and fill states; a next address waits for it.
// Reset: arst_n clears control state and counters; the page table is then cleared one entry
// per cycle, during which no address is taken.
`default_nettype none

`include "tlb_page_table_translator_assert.svh"

module tlb_page_table_translator #(
	parameter int unsigned TLB_ENTRIES = 16,
	parameter int unsigned PAGE_COUNT  = 256,
	parameter int unsigned FRAME_COUNT = 256,
	parameter int unsigned OFFSET_BITS = 8
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// configuration write channel
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [8:0]  frames_in_use,
	// address channel
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [15:0] virt_addr,
	// result channel
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [15:0]      phys_addr,
	output logic             tlb_hit,
	output logic             page_fault,
	output logic [7:0]       fetch_page,
	output logic [7:0]       fetch_frame,
	output logic             evicted_valid,
	output logic [7:0]       evicted_page,
	output logic [31:0]      hit_total,
	output logic [31:0]      fault_total,
	output logic [31:0]      access_total
);

	tlbpt_pkg::cmd_t  cmd;
	tlbpt_pkg::stat_t stat;
	logic cfg_we;

	// Take a frame-limit word whenever one is offered; the user must write only while idle, the block does not enforce it.
	assign cfg_ready = 1'b1;
	assign cfg_we    = cfg_valid && cfg_ready;

	// Controller: sequence clear pass, lookup, eviction and result load.
	tlbpt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.stat      (stat),
		.cmd       (cmd)
	);

	// Datapath: TLB, page table, frame owners, FIFO pointers, counters, result word.
	tlbpt_dp #(
		.TLB_ENTRIES (TLB_ENTRIES),
		.PAGE_COUNT  (PAGE_COUNT),
		.FRAME_COUNT (FRAME_COUNT),
		.OFFSET_BITS (OFFSET_BITS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_data      (frames_in_use),
		.virt_addr     (virt_addr),
		.cmd           (cmd),
		.stat          (stat),
		.phys_addr     (phys_addr),
		.tlb_hit       (tlb_hit),
		.page_fault    (page_fault),
		.fetch_page    (fetch_page),
		.fetch_frame   (fetch_frame),
		.evicted_valid (evicted_valid),
		.evicted_page  (evicted_page),
		.hit_total     (hit_total),
		.fault_total   (fault_total),
		.access_total  (access_total)
	);

	// Never overwrite a result word that is still waiting.
	`TLBPT_ASSERT_NOW(a_no_overwrite, cmd.load_out, !out_valid || !out_stall, "result word overwritten")
	// Latch an address only on a real handshake.
	`TLBPT_ASSERT_NOW(a_accept_hs, cmd.op == tlbpt_pkg::OP_ACCEPT, in_valid && !in_stall, "bad accept")
	// Follow victim selection by the owner check.
	`TLBPT_ASSERT_NEXT(a_evsel_chk, cmd.op == tlbpt_pkg::OP_EVSEL, cmd.op == tlbpt_pkg::OP_EVCHK, "evict order")
	// Report an eviction only together with a fault.
	`TLBPT_ASSERT_NOW(a_evict_fault, out_valid && evicted_valid, page_fault && !tlb_hit, "eviction without fault")

endmodule

`default_nettype wire

>>> tb/tb.sv
`timescale 1ns / 1ps

module tb;

	localparam int unsigned IDLE_PCT    = 37;
	localparam int unsigned TLB_SLOTS   = 16;
	localparam int unsigned PAGES       = 256;
	localparam int unsigned FRAMES      = 256;
	localparam int unsigned PHASES      = 14;
	localparam int unsigned PHASE_WORDS = 120;

	// One translated word as the result channel carries it.
	typedef struct packed {
		logic [15:0] phys_addr;
		logic        tlb_hit;
		logic        page_fault;
		logic [7:0]  fetch_page;
		logic [7:0]  fetch_frame;
		logic        evicted_valid;
		logic [7:0]  evicted_page;
		logic [31:0] hit_total;
		logic [31:0] fault_total;
		logic [31:0] access_total;
	} xlate_t;

	// Every block input starts at a known value.
	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [8:0]  frames_in_use = 9'd256;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [15:0] virt_addr = 16'd0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [15:0] phys_addr;
	logic        tlb_hit;
	logic        page_fault;
	logic [7:0]  fetch_page;
	logic [7:0]  fetch_frame;
	logic        evicted_valid;
	logic [7:0]  evicted_page;
	logic [31:0] hit_total;
	logic [31:0] fault_total;
	logic [31:0] access_total;

	// Translator state as the testbench tracks it.
	logic        page_resident [PAGES];
	logic [7:0]  page_frame [PAGES];
	logic [7:0]  frame_page [FRAMES];
	logic        tlb_live [TLB_SLOTS];
	logic [7:0]  tlb_page [TLB_SLOTS];
	logic [7:0]  tlb_frame [TLB_SLOTS];
	logic [3:0]  tlb_next;
	int unsigned fresh_frame;
	int unsigned victim_frame;
	logic [31:0] hit_count;
	logic [31:0] fault_count;
	logic [31:0] access_count;
	logic [8:0]  frame_limit_setting;

	int unsigned eviction_count = 0;
	int unsigned limit_writes = 0;
	int unsigned errors = 0;

	// High during a stretch in which neither side idles.
	logic steady = 1'b0;

	// Translations accepted on the address channel, oldest first.
	xlate_t pending_translations[$];

	tlb_page_table_translator i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.frames_in_use (frames_in_use),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.virt_addr     (virt_addr),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.phys_addr     (phys_addr),
		.tlb_hit       (tlb_hit),
		.page_fault    (page_fault),
		.fetch_page    (fetch_page),
		.fetch_frame   (fetch_frame),
		.evicted_valid (evicted_valid),
		.evicted_page  (evicted_page),
		.hit_total     (hit_total),
		.fault_total   (fault_total),
		.access_total  (access_total)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Hard stop in case a handshake never completes.
	initial begin
		#(5_000_000);
		$display("%0t ns: timeout, translations still pending: %0d", $time,
			pending_translations.size());
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// Hold off the result channel at random, except in the steady stretch.
	always @(posedge clk) begin
		out_stall <= !steady && ($urandom_range(99) < IDLE_PCT);
	end

	function automatic logic [31:0] bump(input logic [31:0] v);
		return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
	endfunction

	// Translate one address and advance the tracked state: TLB lookup, then
	// page table, then a fresh frame or the oldest loaded one in FIFO order.
	function automatic xlate_t translate(input logic [15:0] addr);
		xlate_t      r;
		logic [7:0]  pg;
		logic [7:0]  fr;
		logic [7:0]  owner;
		logic        found;
		int unsigned lim;
		int unsigned slot;
		r = '0;
		pg = addr[15:8];
		fr = 8'd0;
		found = 1'b0;
		access_count = bump(access_count);
		for (int i = 0; i < TLB_SLOTS; i++) begin
			if (!found && tlb_live[i] && tlb_page[i] == pg) begin
				found = 1'b1;
				fr = tlb_frame[i];
			end
		end
		if (found) begin
			hit_count = bump(hit_count);
		end else begin
			if (page_resident[pg]) begin
				fr = page_frame[pg];
			end else begin
				// clamp the limit: zero acts as one, anything past the frame count as the count
				lim = frame_limit_setting;
				if (lim == 0)
					lim = 1;
				if (lim > FRAMES)
					lim = FRAMES;
				fault_count = bump(fault_count);
				r.page_fault = 1'b1;
				if (fresh_frame < lim) begin
					fr = 8'(fresh_frame);
					fresh_frame++;
				end else begin
					// restart at frame 0 when the limit dropped below the pointer
					slot = (victim_frame < lim) ? victim_frame : 0;
					victim_frame = (slot + 1 >= lim) ? 0 : slot + 1;
					fr = 8'(slot);
					owner = frame_page[fr];
					if (page_resident[owner] && page_frame[owner] == fr) begin
						page_resident[owner] = 1'b0;
						for (int i = 0; i < TLB_SLOTS; i++) begin
							if (tlb_live[i] && tlb_page[i] == owner)
								tlb_live[i] = 1'b0;
						end
						r.evicted_valid = 1'b1;
						r.evicted_page = owner;
						eviction_count++;
					end
				end
				frame_page[fr] = pg;
				page_resident[pg] = 1'b1;
				page_frame[pg] = fr;
				r.fetch_page = pg;
				r.fetch_frame = fr;
			end
			// every miss refills the TLB at the FIFO fill pointer
			tlb_live[tlb_next] = 1'b1;
			tlb_page[tlb_next] = pg;
			tlb_frame[tlb_next] = fr;
			tlb_next++;
		end
		r.phys_addr = {fr, addr[7:0]};
		r.tlb_hit = found;
		r.hit_total = hit_count;
		r.fault_total = fault_count;
		r.access_total = access_count;
		return r;
	endfunction

	task automatic check_field(input string name, input logic [31:0] want,
		input logic [31:0] got);
		if (want !== got) begin
			errors++;
			$display("%0t ns: %s mismatch: expected 0x%0h, got 0x%0h", $time, name,
				want, got);
		end
	endtask

	// Compare each word taken from the result channel with the oldest translation.
	always @(posedge clk) begin
		xlate_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_translations.size() == 0) begin
				errors++;
				$display("%0t ns: unexpected word: expected none, got address 0x%0h",
					$time, phys_addr);
			end else begin
				want = pending_translations.pop_front();
				check_field("phys_addr", 32'(want.phys_addr), 32'(phys_addr));
				check_field("tlb_hit", 32'(want.tlb_hit), 32'(tlb_hit));
				check_field("page_fault", 32'(want.page_fault), 32'(page_fault));
				check_field("fetch_page", 32'(want.fetch_page), 32'(fetch_page));
				check_field("fetch_frame", 32'(want.fetch_frame), 32'(fetch_frame));
				check_field("evicted_valid", 32'(want.evicted_valid), 32'(evicted_valid));
				check_field("evicted_page", 32'(want.evicted_page), 32'(evicted_page));
				check_field("hit_total", want.hit_total, hit_total);
				check_field("fault_total", want.fault_total, fault_total);
				check_field("access_total", want.access_total, access_total);
			end
		end
	end

	// Send one address word. Valid stays high on return so that a word sent
	// in the same step follows without a gap; idle first at random.
	task automatic send_address(input logic [15:0] addr);
		if (!steady && $urandom_range(99) < IDLE_PCT) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < IDLE_PCT);
		end
		in_valid <= 1'b1;
		virt_addr <= addr;
		do @(posedge clk); while (in_stall);
		pending_translations.push_back(translate(addr));
	endtask

	// Drop valid and hold until every pending translation has come back.
	task automatic drain_results();
		in_valid <= 1'b0;
		while (pending_translations.size() != 0)
			@(posedge clk);
	endtask

	// Write the frame limit once the block has gone quiet.
	task automatic write_frame_limit(input logic [8:0] value);
		drain_results();
		frames_in_use <= value;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		frame_limit_setting = value;
		limit_writes++;
	endtask

	// Address extremes, first faults, TLB hits, and a page pushed out of the
	// TLB that is then found in the page table.
	task automatic test_first_touch();
		send_address(16'h0000);
		send_address(16'hFFFF);
		send_address(16'h00AA);
		for (int pg = 1; pg <= 15; pg++)
			send_address({8'(pg), (pg % 2 == 1) ? 8'h55 : 8'hAA});
		// page 0 lost its TLB slot to page 15
		send_address(16'h0033);
	endtask

	// Limit lowered below the frames in use, zero limit, limit past the frame
	// count, and a raised limit that hands out fresh frames again.
	task automatic test_limit_edges();
		write_frame_limit(9'd1);
		send_address(16'h2011);
		send_address(16'h2122);
		// page FF sits above the new limit and keeps its frame
		send_address(16'hFF00);
		write_frame_limit(9'd0);
		send_address(16'h2233);
		send_address(16'h2144);
		write_frame_limit(9'd511);
		send_address(16'h2355);
		send_address(16'h0066);
		write_frame_limit(9'd256);
	endtask

	// Random traffic, mostly over a small working set of pages so that hits
	// and evictions are frequent, under a series of frame limits.
	task automatic test_random_phases();
		logic [8:0]  lim;
		logic [7:0]  base;
		logic [15:0] addr;
		logic [15:0] last;
		int unsigned span;
		int unsigned pick;
		last = 16'd0;
		for (int p = 0; p < PHASES; p++) begin
			case (p)
				0: lim = 9'd256;
				1: lim = 9'd2;
				2: lim = 9'd16;
				3: lim = 9'd5;
				4: lim = 9'd1;
				5: lim = 9'd300;
				6: lim = 9'd64;
				7: lim = 9'd3;
				8: lim = 9'd511;
				9: lim = 9'd8;
				10: lim = 9'd0;
				11: lim = 9'd128;
				12: lim = 9'd20;
				default: lim = 9'($urandom_range(1, 511));
			endcase
			write_frame_limit(lim);
			// first phase runs with no idling on either side
			steady = (p == 0);
			span = $urandom_range(1, 40);
			base = 8'($urandom_range(0, 255));
			for (int n = 0; n < PHASE_WORDS; n++) begin
				// hold the sender mid-phase until the results catch up
				if (p == 6 && n == PHASE_WORDS / 2)
					drain_results();
				if ($urandom_range(49) == 0) begin
					span = $urandom_range(1, 40);
					base = 8'($urandom_range(0, 255));
				end
				pick = $urandom_range(99);
				if (pick < 20)
					addr = 16'($urandom);
				else if (pick < 30)
					addr = last;
				else
					addr = {8'(base + $urandom_range(0, span - 1)), 8'($urandom)};
				send_address(addr);
				last = addr;
			end
		end
		steady = 1'b0;
	endtask

	initial begin
		for (int i = 0; i < PAGES; i++) begin
			page_resident[i] = 1'b0;
			page_frame[i] = 8'd0;
		end
		for (int i = 0; i < FRAMES; i++)
			frame_page[i] = 8'd0;
		for (int i = 0; i < TLB_SLOTS; i++) begin
			tlb_live[i] = 1'b0;
			tlb_page[i] = 8'd0;
			tlb_frame[i] = 8'd0;
		end
		tlb_next = 4'd0;
		fresh_frame = 0;
		victim_frame = 0;
		hit_count = 32'd0;
		fault_count = 32'd0;
		access_count = 32'd0;
		frame_limit_setting = 9'd256;

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		test_first_touch();
		test_limit_edges();
		test_random_phases();

		// wait out the last words, then a short tail for stray output
		drain_results();
		repeat (20) @(posedge clk);

		$display("Translated %0d addresses across %0d frame-limit writes:", access_count,
			limit_writes);
		$display("%0d TLB hits, %0d page faults, %0d evictions.", hit_count, fault_count,
			eviction_count);
		if (errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
